FILE: sv/atxbcb_pkg.sv
// Shared types, command table and codes for the ATX button command bridge.
package atxbcb_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] CMD_RST_ON  = 2'd0;
  localparam logic [1:0] CMD_RST_OFF = 2'd1;
  localparam logic [1:0] CMD_PWR_ON  = 2'd2;
  localparam logic [1:0] CMD_PWR_OFF = 2'd3;

  localparam int NUM_CMDS = 4;

  localparam logic       REG_REPORT_PERIOD = 1'b0;
  localparam logic       REG_BLINK_LENGTH  = 1'b1;
  localparam logic [15:0] REPORT_PERIOD_RESET = 16'd100;
  localparam logic [15:0] BLINK_LENGTH_RESET  = 16'd20;

  localparam logic [7:0]  NEWLINE  = 8'h0A;
  localparam logic [16:0] TICK_SAT = 17'h1FFFF;

  // Command text, right-aligned: the first character sits in the highest used byte
  localparam logic [95:0] CMD_TEXT [NUM_CMDS] = '{
    96'({"BTN_", "RST_ON\n"}),
    96'({"BTN_", "RST_OFF\n"}),
    96'({"BTN_", "PWR_ON\n"}),
    96'({"BTN_", "PWR_OFF\n"})
  };
  localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{4'd11, 4'd12, 4'd11, 4'd12};

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic       mb_hdd_led_level;
    logic       mb_pwr_led_level;
    logic       case_rst_level;
    logic       case_pwr_level;
  } item_t;

  typedef struct packed {
    logic mb_rst_drive;
    logic mb_pwr_drive;
    logic case_hdd_led_drive;
    logic case_pwr_led_drive;
    logic activity_led;
    logic report_valid;
    logic report_hdd_active;
    logic report_pwr_active;
    logic report_rst_line;
    logic report_pwr_line;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } cmd_t;

  // Character of command idx at line position pos; zero past the end
  function automatic logic [7:0] cmd_char(input logic [1:0] idx, input logic [3:0] pos);
    logic [3:0] k;
    logic [7:0] c;
    k = CMD_LEN[idx] - 4'd1 - pos;
    c = 8'd0;
    if (pos < CMD_LEN[idx]) begin
      c = CMD_TEXT[idx][{k, 3'b000} +: 8];
    end
    return c;
  endfunction

endpackage

FILE: sv/atxbcb_line_match.sv
// Line assembler and on-the-fly matcher for the four button commands.
module atxbcb_line_match #(
  parameter int LINE_LIMIT = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_en,
  input  logic [7:0]          rx_byte,
  output atxbcb_pkg::cmd_t    cmd
);
  import atxbcb_pkg::*;

  localparam int PW = $clog2(LINE_LIMIT);
  localparam logic [PW-1:0] LAST_POS = PW'(LINE_LIMIT - 1);

  logic [PW-1:0]       line_position;
  logic [NUM_CMDS-1:0] candidate_alive;

  logic [PW-1:0]       pos_inc;
  logic [NUM_CMDS-1:0] alive_next;
  logic                line_end;
  cmd_t                hit;

  always_comb begin
    for (int i = 0; i < NUM_CMDS; i++) begin
      alive_next[i] = candidate_alive[i] && (line_position < PW'(CMD_LEN[i])) &&
                      (cmd_char(2'(i), line_position[3:0]) == rx_byte);
    end
    pos_inc  = line_position + PW'(1);
    line_end = (rx_byte == NEWLINE) || (pos_inc >= LAST_POS);
    hit      = '0;
    for (int i = 0; i < NUM_CMDS; i++) begin
      if (alive_next[i] && pos_inc == PW'(CMD_LEN[i])) begin
        hit.valid = 1'b1;
        hit.code  = 2'(i);
      end
    end
    cmd       = hit;
    cmd.valid = hit.valid && byte_en && line_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position   <= '0;
      candidate_alive <= '1;
    end else if (byte_en) begin
      if (line_end) begin
        line_position   <= '0;
        candidate_alive <= '1;
      end else begin
        line_position   <= pos_inc;
        candidate_alive <= alive_next;
      end
    end
  end

endmodule

FILE: sv/atxbcb_status.sv
// Remote latches set on commands; activity blink and status report per poll tick.
module atxbcb_status (
  input  logic                clk,
  input  logic                rst,
  input  atxbcb_pkg::cmd_t    cmd,
  input  logic                tick_en,
  input  atxbcb_pkg::item_t   sample,
  input  logic [15:0]         report_period,
  input  logic [15:0]         blink_length,
  output atxbcb_pkg::result_t result
);
  import atxbcb_pkg::*;

  logic        remote_rst_latch;
  logic        remote_pwr_latch;
  logic        command_pending;
  logic        activity_lit;
  logic [15:0] blink_remaining;
  logic [16:0] ticks_since_report;
  logic [3:0]  last_reported_bits;

  logic        activity_lit_next;
  logic [15:0] blink_remaining_next;
  logic [16:0] ticks_inc;
  logic [3:0]  bits;
  logic        rst_drv;
  logic        pwr_drv;
  logic        send;

  always_comb begin
    activity_lit_next    = activity_lit;
    blink_remaining_next = blink_remaining;
    if (command_pending) begin
      activity_lit_next    = 1'b1;
      blink_remaining_next = blink_length;
    end else if (activity_lit) begin
      if (blink_remaining <= 16'd1) begin
        activity_lit_next    = 1'b0;
        blink_remaining_next = '0;
      end else begin
        blink_remaining_next = blink_remaining - 16'd1;
      end
    end

    rst_drv   = !(remote_rst_latch || !sample.case_rst_level);
    pwr_drv   = !(remote_pwr_latch || !sample.case_pwr_level);
    bits      = {~sample.mb_hdd_led_level, ~sample.mb_pwr_led_level, rst_drv, pwr_drv};
    ticks_inc = (ticks_since_report == TICK_SAT) ? ticks_since_report
                                                 : ticks_since_report + 17'd1;
    send      = (bits != last_reported_bits) || (ticks_inc > {1'b0, report_period});

    result.mb_rst_drive       = rst_drv;
    result.mb_pwr_drive       = pwr_drv;
    result.case_hdd_led_drive = sample.mb_hdd_led_level;
    result.case_pwr_led_drive = sample.mb_pwr_led_level;
    result.activity_led       = activity_lit_next;
    result.report_valid       = send;
    result.report_hdd_active  = bits[3];
    result.report_pwr_active  = bits[2];
    result.report_rst_line    = bits[1];
    result.report_pwr_line    = bits[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_rst_latch   <= 1'b0;
      remote_pwr_latch   <= 1'b0;
      command_pending    <= 1'b0;
      activity_lit       <= 1'b0;
      blink_remaining    <= '0;
      ticks_since_report <= '0;
      last_reported_bits <= '0;
    end else begin
      if (cmd.valid) begin
        command_pending <= 1'b1;
        case (cmd.code)
          CMD_RST_ON:  remote_rst_latch <= 1'b1;
          CMD_RST_OFF: remote_rst_latch <= 1'b0;
          CMD_PWR_ON:  remote_pwr_latch <= 1'b1;
          CMD_PWR_OFF: remote_pwr_latch <= 1'b0;
          default:     remote_rst_latch <= remote_rst_latch;
        endcase
      end
      if (tick_en) begin
        command_pending <= 1'b0;
        activity_lit    <= activity_lit_next;
        blink_remaining <= blink_remaining_next;
        if (send) begin
          last_reported_bits <= bits;
          ticks_since_report <= '0;
        end else begin
          ticks_since_report <= ticks_inc;
        end
      end
    end
  end

endmodule

FILE: sv/atx_button_command_bridge_top.sv
// Top level of the ATX button command bridge: input register, result register, config.
// One transaction is taken per clock unless stalled. Serial bytes are registered,
// matched against the button commands in the following cycle and give no result; a poll
// tick's result is held in the result register until taken. The input register
// keeps accepting while a result waits, and stalls only when a tick finds the result
// register still full. Register 0 is report_period, register 1 is blink_length.
module atx_button_command_bridge_top #(
  parameter int LINE_LIMIT = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  atxbcb_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output atxbcb_pkg::result_t result,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import atxbcb_pkg::*;

  item_t       item_q;
  logic        full_q;
  logic        advance;
  logic        tick_en;
  logic        byte_en;
  logic [15:0] report_period;
  logic [15:0] blink_length;
  cmd_t        cmd;
  result_t     result_next;

  assign advance    = full_q && (item_q.opcode == OP_BYTE || !result_valid || result_ready);
  assign item_ready = !full_q || advance;
  assign tick_en    = advance && item_q.opcode == OP_TICK;
  assign byte_en    = advance && item_q.opcode == OP_BYTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_q <= 1'b0;
    end else if (item_valid && item_ready) begin
      full_q <= 1'b1;
    end else if (advance) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_period <= REPORT_PERIOD_RESET;
      blink_length  <= BLINK_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REPORT_PERIOD: report_period <= cfg_data;
        REG_BLINK_LENGTH:  blink_length  <= cfg_data;
        default:           report_period <= report_period;
      endcase
    end
  end

  atxbcb_line_match #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_line_match (
    .clk     (clk),
    .rst     (rst),
    .byte_en (byte_en),
    .rx_byte (item_q.rx_byte),
    .cmd     (cmd)
  );

  atxbcb_status u_status (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .tick_en       (tick_en),
    .sample        (item_q),
    .report_period (report_period),
    .blink_length  (blink_length),
    .result        (result_next)
  );

  // Hold the result until taken; refill on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tick_en) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      result <= result_next;
    end
  end

endmodule
